// ===== design/u31au_pkg.sv =====
// Package with word widths, opcodes, pipeline stage type and the division and multiply step.
`timescale 1ns / 1ps
`default_nettype none

package u31au_pkg;

    localparam int WORD_BITS = 31;
    localparam int OP_BITS   = 3;

    // Stream widths, rounded up to whole bytes.
    localparam int S_DATA_BITS = ((3 * WORD_BITS + 7) / 8) * 8;
    localparam int M_DATA_BITS = ((2 * WORD_BITS + 7) / 8) * 8;

    typedef enum logic [OP_BITS-1:0] {
        OP_LT      = 3'd0,
        OP_LE      = 3'd1,
        OP_CMP     = 3'd2,
        OP_MUL     = 3'd3,
        OP_DIV2W   = 3'd4,
        OP_DIVREM  = 3'd5,
        OP_MOD     = 3'd6
    } t_opcode;

    localparam logic [WORD_BITS-1:0] CMP_EQ = WORD_BITS'(0);
    localparam logic [WORD_BITS-1:0] CMP_LT = WORD_BITS'(1);
    localparam logic [WORD_BITS-1:0] CMP_GT = WORD_BITS'(2);

    // One pipeline stage. While div_active is set, rem holds the partial
    // remainder and quo_num holds the unused dividend bits at the top and the
    // quotient bits gathered so far at the bottom. While mul_active is set,
    // divisor holds the multiplicand, rem the high product word so far and
    // quo_num the low product bits at the top and the unused multiplier bits
    // at the bottom. Otherwise rem and quo_num carry the final low and high
    // words unchanged.
    typedef struct packed {
        logic                 div_active;
        logic                 mul_active;
        logic                 zero_high;
        logic                 div_error;
        logic [WORD_BITS-1:0] rem;
        logic [WORD_BITS-1:0] quo_num;
        logic [WORD_BITS-1:0] divisor;
    } t_stage;

    // One restoring division step or one shift-and-add multiply step.
    function automatic t_stage div_step(input t_stage s);
        t_stage             o;
        logic [WORD_BITS:0] trial;
        logic [WORD_BITS:0] diff;
        logic [WORD_BITS:0] sum;
        logic               take;
        o     = s;
        trial = {s.rem, s.quo_num[WORD_BITS-1]};
        diff  = trial - {1'b0, s.divisor};
        take  = (trial >= {1'b0, s.divisor});
        sum   = {1'b0, s.rem} + (s.quo_num[0] ? {1'b0, s.divisor} : '0);
        if (s.div_active) begin
            o.rem     = take ? diff[WORD_BITS-1:0] : trial[WORD_BITS-1:0];
            o.quo_num = {s.quo_num[WORD_BITS-2:0], take};
        end else if (s.mul_active) begin
            o.rem     = sum[WORD_BITS:1];
            o.quo_num = {sum[0], s.quo_num[WORD_BITS-1:1]};
        end
        return o;
    endfunction

endpackage

`default_nettype wire

// ===== design/uint31_arith_unit.sv =====
// Pipelined unsigned compare, multiply and divide unit on 31-bit words.
// Pipeline: input register, one step per stage, output register.
// Throughput: one beat per cycle unless stalled; multiply and restoring divide are unrolled one bit per stage.
// The whole pipeline holds while the output register is full and not taken.
// Reset (synchronous, active low) clears all valid bits; data registers are not reset.
`timescale 1ns / 1ps
`default_nettype none

module uint31_arith_unit
    import u31au_pkg::*;
(
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    s_axis_tvalid,
    output logic                   s_axis_tready,
    // operand_a, operand_b, divisor_wide from the lowest bit up, zero padded
    input  wire  [S_DATA_BITS-1:0] s_axis_tdata,
    // opcode
    input  wire  [OP_BITS-1:0]     s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  wire                    m_axis_tready,
    // result_high, result_low from the lowest bit up, zero padded
    output logic [M_DATA_BITS-1:0] m_axis_tdata,
    // divide_error
    output logic [0:0]             m_axis_tuser
);

    logic [WORD_BITS-1:0]   w_a;
    logic [WORD_BITS-1:0]   w_b;
    logic [WORD_BITS-1:0]   w_d;
    t_opcode                w_op;
    logic                   w_adv;

    t_stage n_stg [0:WORD_BITS];
    t_stage r_stg [0:WORD_BITS];
    logic   r_vld [0:WORD_BITS];

    logic                 r_out_vld;
    logic [WORD_BITS-1:0] r_out_high;
    logic [WORD_BITS-1:0] r_out_low;
    logic                 r_out_err;

    assign w_a    = s_axis_tdata[WORD_BITS-1:0];
    assign w_b    = s_axis_tdata[2*WORD_BITS-1:WORD_BITS];
    assign w_d    = s_axis_tdata[3*WORD_BITS-1:2*WORD_BITS];
    assign w_op   = t_opcode'(s_axis_tuser);

    // The pipeline moves as a whole whenever the output register can take a beat.
    assign w_adv         = !r_out_vld || m_axis_tready;
    assign s_axis_tready = w_adv;

    always_comb begin
        n_stg[0]            = '0;
        n_stg[0].divisor    = w_d;
        case (w_op)
            OP_LT: begin
                n_stg[0].rem = (w_a < w_b) ? WORD_BITS'(1) : WORD_BITS'(0);
            end
            OP_LE: begin
                n_stg[0].rem = (w_a <= w_b) ? WORD_BITS'(1) : WORD_BITS'(0);
            end
            OP_CMP: begin
                if (w_a < w_b) begin
                    n_stg[0].rem = CMP_LT;
                end else if (w_a == w_b) begin
                    n_stg[0].rem = CMP_EQ;
                end else begin
                    n_stg[0].rem = CMP_GT;
                end
            end
            OP_MUL: begin
                n_stg[0].mul_active = 1'b1;
                n_stg[0].divisor    = w_a;
                n_stg[0].quo_num    = w_b;
            end
            OP_DIV2W: begin
                // The quotient of the two-word dividend fits in one word only when the high word is below the divisor.
                if (w_d == '0 || w_a >= w_d) begin
                    n_stg[0].div_error = 1'b1;
                end else begin
                    n_stg[0].div_active = 1'b1;
                    n_stg[0].rem        = w_a;
                    n_stg[0].quo_num    = w_b;
                end
            end
            OP_DIVREM, OP_MOD: begin
                n_stg[0].divisor   = w_b;
                n_stg[0].zero_high = (w_op == OP_MOD);
                if (w_b == '0) begin
                    n_stg[0].div_error = 1'b1;
                end else begin
                    n_stg[0].div_active = 1'b1;
                    n_stg[0].quo_num    = w_a;
                end
            end
            default: begin
                n_stg[0].rem = '0;
            end
        endcase
        for (int k = 1; k <= WORD_BITS; k++) begin
            n_stg[k] = div_step(r_stg[k-1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int k = 0; k <= WORD_BITS; k++) begin
                r_stg[k] <= n_stg[k];
            end
            // A finished product has its high word in rem and its low word in quo_num.
            if (r_stg[WORD_BITS].mul_active) begin
                r_out_high <= r_stg[WORD_BITS].rem;
                r_out_low  <= r_stg[WORD_BITS].quo_num;
            end else begin
                r_out_high <= r_stg[WORD_BITS].zero_high ? '0 : r_stg[WORD_BITS].quo_num;
                r_out_low  <= r_stg[WORD_BITS].rem;
            end
            r_out_err  <= r_stg[WORD_BITS].div_error;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= WORD_BITS; k++) begin
                r_vld[k] <= 1'b0;
            end
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_vld[0] <= s_axis_tvalid;
            for (int k = 1; k <= WORD_BITS; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
            r_out_vld <= r_vld[WORD_BITS];
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {{(M_DATA_BITS - 2*WORD_BITS){1'b0}}, r_out_low, r_out_high};
    assign m_axis_tuser  = r_out_err;

endmodule

`default_nettype wire

// ===== design/u31au_checker.sv =====
// Port-level checker for the arithmetic unit, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module u31au_checker
    import u31au_pkg::*;
(
    input wire                   i_clk,
    input wire                   i_rst_n,
    input wire                   s_axis_tready,
    input wire                   m_axis_tvalid,
    input wire                   m_axis_tready,
    input wire [M_DATA_BITS-1:0] m_axis_tdata,
    input wire [0:0]             m_axis_tuser
);

    // A failed division reports zero words.
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata == '0))
        else $error("divide error beat carries nonzero data");

    // With the output register empty the unit always takes input.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled while output is empty");

    // Nothing is presented in the cycle after reset.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid right after reset");

    // A stalled output beat holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("stalled output beat changed");

endmodule

bind uint31_arith_unit u31au_checker u_u31au_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

// ===== verif/tb_uint31_arith_unit.sv =====
// Self-checking testbench for the pipelined unsigned 31-bit compare, multiply and divide unit.
`timescale 1ns / 1ps

module tb_uint31_arith_unit;
    import u31au_pkg::*;

    localparam logic [WORD_BITS-1:0] WORD_MAX   = '1;
    localparam logic [OP_BITS-1:0]   OP_UNUSED  = 3'd7;
    localparam int                   RANDOM_OPS = 550;
    localparam int                   PIPE_DEPTH = WORD_BITS + 2;
    localparam int                   CYCLE_LIMIT = 300000;

    typedef struct packed {
        logic [OP_BITS-1:0]   opcode;
        logic [WORD_BITS-1:0] a;
        logic [WORD_BITS-1:0] b;
        logic [WORD_BITS-1:0] d;
        logic                 drain_first;
    } t_op_req;

    typedef struct packed {
        logic [OP_BITS-1:0]   opcode;
        logic [WORD_BITS-1:0] high;
        logic [WORD_BITS-1:0] low;
        logic                 err;
    } t_op_ans;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [S_DATA_BITS-1:0] s_axis_tdata  = '0;
    logic [OP_BITS-1:0]     s_axis_tuser  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [M_DATA_BITS-1:0] m_axis_tdata;
    logic [0:0]             m_axis_tuser;

    t_op_req requests_q[$];
    t_op_ans answers_due[$];
    t_op_req cur_req;

    logic s_fire    = 1'b0;
    logic m_fire    = 1'b0;
    logic hold_done = 1'b0;
    int   hold_left = 0;
    int   src_gap   = 0;
    int   sink_gap  = 0;
    bit   src_steady  = 1'b0;
    bit   sink_steady = 1'b0;
    int   accepted     = 0;
    int   mismatch_cnt = 0;
    int   cycle_cnt    = 0;

    uint31_arith_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Operand mix: full random words, small values, values near the top and powers of two.
    function automatic logic [WORD_BITS-1:0] rand_word();
        logic [WORD_BITS-1:0] w;
        w = WORD_BITS'($urandom);
        case ($urandom_range(0, 4))
            0: w = WORD_BITS'($urandom_range(0, 15));
            1: w = WORD_MAX - WORD_BITS'($urandom_range(0, 15));
            2: w = WORD_BITS'(1) << $urandom_range(0, WORD_BITS - 1);
            default: ;
        endcase
        return w;
    endfunction

    function automatic t_op_ans compute_answer(input t_op_req q);
        t_op_ans                ans;
        logic [2*WORD_BITS-1:0] wide;
        logic [2*WORD_BITS-1:0] dvs;
        ans        = '0;
        ans.opcode = q.opcode;
        case (q.opcode)
            OP_LT:  ans.low = WORD_BITS'(q.a < q.b);
            OP_LE:  ans.low = WORD_BITS'(q.a <= q.b);
            OP_CMP: ans.low = (q.a < q.b) ? CMP_LT : ((q.a == q.b) ? CMP_EQ : CMP_GT);
            OP_MUL: begin
                wide     = {{WORD_BITS{1'b0}}, q.a} * {{WORD_BITS{1'b0}}, q.b};
                ans.high = wide[2*WORD_BITS-1:WORD_BITS];
                ans.low  = wide[WORD_BITS-1:0];
            end
            OP_DIV2W: begin
                // The quotient only fits in one word while the high dividend word is below d.
                if (q.d == 0 || q.a >= q.d) begin
                    ans.err = 1'b1;
                end else begin
                    wide     = {q.a, q.b};
                    dvs      = {{WORD_BITS{1'b0}}, q.d};
                    ans.high = WORD_BITS'(wide / dvs);
                    ans.low  = WORD_BITS'(wide % dvs);
                end
            end
            OP_DIVREM: begin
                if (q.b == 0) begin
                    ans.err = 1'b1;
                end else begin
                    ans.high = q.a / q.b;
                    ans.low  = q.a % q.b;
                end
            end
            OP_MOD: begin
                if (q.b == 0) ans.err = 1'b1;
                else ans.low = q.a % q.b;
            end
            default: ;
        endcase
        return ans;
    endfunction

    task automatic queue_request(input logic [OP_BITS-1:0] op,
                                 input logic [WORD_BITS-1:0] a, b, d,
                                 input logic drain);
        t_op_req r;
        r.opcode      = op;
        r.a           = a;
        r.b           = b;
        r.d           = d;
        r.drain_first = drain;
        requests_q.push_back(r);
    endtask

    task automatic report_mismatch(input string line);
        mismatch_cnt++;
        if (mismatch_cnt <= 40) $display("%0t: %s", $time, line);
    endtask

    // Source side: one beat per request, random gaps between beats.
    always @(negedge i_clk) begin : drive_src
        logic offer;
        offer = s_axis_tvalid;
        if (i_rst_n) begin
            if (s_fire) begin
                offer = 1'b0;
                if ($urandom_range(0, 39) == 0) src_steady = !src_steady;
                src_gap = src_steady ? 0 : $urandom_range(0, 16);
            end
            if (!offer && requests_q.size() != 0) begin
                if (src_gap != 0) begin
                    src_gap--;
                end else if (!requests_q[0].drain_first || answers_due.size() == 0) begin
                    cur_req      = requests_q.pop_front();
                    s_axis_tdata <= S_DATA_BITS'({cur_req.d, cur_req.b, cur_req.a});
                    s_axis_tuser <= cur_req.opcode;
                    offer        = 1'b1;
                end
            end
        end
        s_axis_tvalid <= offer;
    end

    // One long output stall once the pipeline is busy, so that it backs up to the input.
    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && accepted >= 150) begin
            hold_left <= 200;
            hold_done <= 1'b1;
        end
    end

    always @(negedge i_clk) begin : drive_sink
        logic take;
        if (m_fire) begin
            if ($urandom_range(0, 39) == 0) sink_steady = !sink_steady;
            sink_gap = sink_steady ? 0 : $urandom_range(0, 16);
        end
        if (hold_left != 0) begin
            take = 1'b0;
        end else if (sink_gap != 0) begin
            sink_gap--;
            take = 1'b0;
        end else begin
            take = 1'b1;
        end
        m_axis_tready <= take;
    end

    always @(posedge i_clk) begin : monitor
        t_op_ans got;
        t_op_ans want;
        cycle_cnt++;
        s_fire <= i_rst_n && s_axis_tvalid && s_axis_tready;
        m_fire <= i_rst_n && m_axis_tvalid && m_axis_tready;
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            answers_due.push_back(compute_answer(cur_req));
            accepted++;
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.high = m_axis_tdata[WORD_BITS-1:0];
            got.low  = m_axis_tdata[2*WORD_BITS-1:WORD_BITS];
            got.err  = m_axis_tuser[0];
            if (answers_due.size() == 0) begin
                report_mismatch($sformatf("result beat with none pending: high %h low %h err %b",
                                          got.high, got.low, got.err));
            end else begin
                want = answers_due.pop_front();
                if (got.high !== want.high)
                    report_mismatch($sformatf("op %0d result_high: got %h want %h",
                                              want.opcode, got.high, want.high));
                if (got.low !== want.low)
                    report_mismatch($sformatf("op %0d result_low: got %h want %h",
                                              want.opcode, got.low, want.low));
                if (got.err !== want.err)
                    report_mismatch($sformatf("op %0d divide_error: got %b want %b",
                                              want.opcode, got.err, want.err));
            end
        end
    end

    initial begin : watchdog
        wait (cycle_cnt >= CYCLE_LIMIT);
        $display("Mismatches found");
        $finish;
    end

    initial begin : stimulus
        t_op_req r;
        int      total;
        int      i;

        // Comparisons at the extremes, equal and unequal, then multiplies by zero, one and the largest word.
        queue_request(OP_LT, 0, 0, rand_word(), 1'b0);
        queue_request(OP_LT, 0, WORD_MAX, rand_word(), 1'b0);
        queue_request(OP_LT, WORD_MAX, 0, rand_word(), 1'b0);
        queue_request(OP_LE, 5, 5, rand_word(), 1'b0);
        queue_request(OP_LE, WORD_MAX, WORD_MAX - WORD_BITS'(1), rand_word(), 1'b0);
        queue_request(OP_CMP, WORD_MAX, WORD_MAX, rand_word(), 1'b0);
        queue_request(OP_CMP, 1, 2, rand_word(), 1'b0);
        queue_request(OP_CMP, WORD_MAX, 0, rand_word(), 1'b0);
        queue_request(OP_MUL, WORD_MAX, WORD_MAX, rand_word(), 1'b0);
        queue_request(OP_MUL, 0, WORD_MAX, rand_word(), 1'b0);
        queue_request(OP_MUL, 1, 12345, rand_word(), 1'b0);
        // Two-word divide: largest quotient, zero divisor, overflow, unnormalized divisor.
        queue_request(OP_DIV2W, 0, WORD_MAX, WORD_MAX, 1'b0);
        queue_request(OP_DIV2W, WORD_MAX - WORD_BITS'(1), WORD_MAX, WORD_MAX, 1'b0);
        queue_request(OP_DIV2W, 0, WORD_MAX, 0, 1'b0);
        queue_request(OP_DIV2W, 5, rand_word(), 5, 1'b0);
        queue_request(OP_DIV2W, WORD_MAX, WORD_MAX, WORD_MAX, 1'b0);
        queue_request(OP_DIV2W, 2, WORD_BITS'($urandom), 3, 1'b0);
        queue_request(OP_DIVREM, WORD_MAX, 1, rand_word(), 1'b0);
        queue_request(OP_DIVREM, 7, 0, rand_word(), 1'b0);
        queue_request(OP_DIVREM, 3, WORD_MAX, rand_word(), 1'b0);
        queue_request(OP_MOD, WORD_MAX, 2, rand_word(), 1'b0);
        queue_request(OP_MOD, 5, 0, rand_word(), 1'b0);
        queue_request(OP_UNUSED, WORD_MAX, WORD_MAX, WORD_MAX, 1'b0);

        for (i = 0; i < RANDOM_OPS; i++) begin
            r.opcode      = OP_BITS'($urandom_range(0, 6));
            r.a           = rand_word();
            r.b           = rand_word();
            r.d           = rand_word();
            r.drain_first = (i == 0 || i == 270 || i == 420);
            case (r.opcode)
                OP_LT, OP_LE, OP_CMP: begin
                    if ($urandom_range(0, 3) == 0) r.b = r.a;
                end
                OP_DIV2W: begin
                    // Mostly dividends that fit, so the quotient path gets exercised.
                    if ($urandom_range(0, 7) != 0) begin
                        if (r.d == 0) r.d = 1;
                        r.a = WORD_BITS'($urandom % r.d);
                    end
                end
                default: ;
            endcase
            requests_q.push_back(r);
        end
        total = requests_q.size();

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        wait (accepted == total);
        wait (answers_due.size() == 0);
        repeat (PIPE_DEPTH + 8) @(posedge i_clk);
        if (mismatch_cnt == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
